FILE: hdl/tli_pkg.sv
`timescale 1ns / 1ps

package tli_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths fixed by the interface
   localparam int DATA_W  = 16;
   localparam int INDEX_W = 6;
   localparam int CSR_W   = 7;
   localparam int STAT_W  = 2;

   // restoring divider: one quotient bit per step over the 32-bit magnitude
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STATUS_EXACT  = 2'd0,
      STATUS_INTERP = 2'd1,
      STATUS_RANGE  = 2'd2,
      STATUS_LOADED = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // write table slot, result = load done
      logic scan_start;  // capture query key and entry count
      logic scan_step;   // issue next table read
      logic set_hit;     // result = matched value
      logic set_range;   // result = out of range
      logic mul;         // product of key and value deltas
      logic div_init;    // load divider with product magnitude
      logic div_step;    // one quotient bit
      logic set_interp;  // result = fa + signed quotient
      logic out_load;    // move result into output register
   } tli_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic too_few;     // fewer than two entries in use
      logic hit;         // exact match seen during scan
      logic found;       // bracketing segment seen during scan
      logic scan_end;    // all reads issued and returned
      logic div_done;    // divider finished
   } tli_sts_type;

endpackage

FILE: hdl/tli_ram.sv
`timescale 1ns / 1ps

module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tli_dp.sv
`timescale 1ns / 1ps

module tli_dp
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_W-1:0]          csr_write_data,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [DATA_W-1:0]  req_entry_key,
   input  logic signed [DATA_W-1:0]  req_entry_value,
   input  logic signed [DATA_W-1:0]  req_query_key,
   input  tli_cmd_type               cmd,
   output tli_sts_type               sts,
   output logic signed [DATA_W-1:0]  rsp_result_value,
   output logic [STAT_W-1:0]         rsp_status
);

   logic [CSR_W-1:0]          csr_ff;
   logic [CNT_W-1:0]          n_sat;

   // scan state
   logic signed [DATA_W-1:0]  x_ff;
   logic [CNT_W-1:0]          n_ff;
   logic [CNT_W-1:0]          rd_addr_ff;
   logic                      rd_vld_ff;
   logic                      rd_first_ff;
   logic signed [DATA_W-1:0]  prev_key_ff;
   logic signed [DATA_W-1:0]  prev_val_ff;
   logic                      hit_ff;
   logic signed [DATA_W-1:0]  hit_val_ff;
   logic                      found_ff;

   // segment deltas
   logic signed [DATA_W:0]    dx_ff;
   logic signed [DATA_W:0]    df_ff;
   logic [DATA_W-1:0]         den_ff;
   logic signed [DATA_W-1:0]  fa_ff;

   // multiply / divide
   logic signed [2*DATA_W+1:0] prod_ff;
   logic                       neg_ff;
   logic [DIV_STEPS-1:0]       quo_ff;
   logic [DATA_W-1:0]          rem_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;

   // result and output registers
   logic signed [DATA_W-1:0]  res_value_ff;
   status_type                res_status_ff;
   logic signed [DATA_W-1:0]  out_value_ff;
   status_type                out_status_ff;

   logic                      wr_en;
   logic                      rd_en;
   logic                      issue;
   logic [2*DATA_W-1:0]       rd_data;
   logic signed [DATA_W-1:0]  key_rd;
   logic signed [DATA_W-1:0]  val_rd;
   logic                      match;
   logic                      bracket;
   logic signed [DATA_W:0]    dx_w;
   logic signed [DATA_W:0]    df_w;
   logic [DATA_W:0]           den_w;
   logic [2*DATA_W+1:0]       prod_abs;
   logic [DATA_W:0]           rem_sh;
   logic                      ge;
   logic [DATA_W:0]           rem_sub;
   logic [DATA_W-1:0]         q16;

   always_comb begin
      if (int'(csr_ff) > TABLE_DEPTH) begin
         n_sat = CNT_W'(TABLE_DEPTH);
      end else begin
         n_sat = CNT_W'(csr_ff);
      end
   end

   assign wr_en = cmd.load && (int'(req_entry_index) < TABLE_DEPTH);
   assign issue = (rd_addr_ff != n_ff);
   assign rd_en = cmd.scan_step && issue;

   tli_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data ({req_entry_key, req_entry_value}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign key_rd = rd_data[2*DATA_W-1:DATA_W];
   assign val_rd = rd_data[DATA_W-1:0];

   assign match   = rd_vld_ff && (key_rd == x_ff);
   assign bracket = rd_vld_ff && !rd_first_ff && (prev_key_ff <= x_ff) && (x_ff <= key_rd);

   assign dx_w  = {x_ff[DATA_W-1], x_ff} - {prev_key_ff[DATA_W-1], prev_key_ff};
   assign df_w  = {val_rd[DATA_W-1], val_rd} - {prev_val_ff[DATA_W-1], prev_val_ff};
   assign den_w = {key_rd[DATA_W-1], key_rd} - {prev_key_ff[DATA_W-1], prev_key_ff};

   assign prod_abs = prod_ff[2*DATA_W+1] ? (-prod_ff) : prod_ff;

   assign rem_sh  = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // only the low bits of the quotient survive the 16-bit result
   assign q16 = neg_ff ? (DATA_W'(0) - quo_ff[DATA_W-1:0]) : quo_ff[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_enable) begin
         csr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         x_ff       <= req_query_key;
         n_ff       <= n_sat;
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (rd_en) begin
            rd_addr_ff  <= rd_addr_ff + CNT_W'(1);
            rd_first_ff <= (rd_addr_ff == '0);
         end
         if (rd_vld_ff) begin
            prev_key_ff <= key_rd;
            prev_val_ff <= val_rd;
         end
         // first match wins
         if (match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_val_ff <= val_rd;
         end
         // last bracketing segment wins
         if (bracket) begin
            found_ff <= 1'b1;
            dx_ff    <= dx_w;
            df_ff    <= df_w;
            den_ff   <= den_w[DATA_W-1:0];
            fa_ff    <= prev_val_ff;
         end
      end

      if (cmd.mul) begin
         prod_ff <= dx_ff * df_ff;
      end

      if (cmd.div_init) begin
         neg_ff     <= prod_ff[2*DATA_W+1];
         quo_ff     <= prod_abs[DIV_STEPS-1:0];
         rem_ff     <= '0;
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_ff     <= {quo_ff[DIV_STEPS-2:0], ge};
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end

      if (cmd.load) begin
         res_value_ff  <= '0;
         res_status_ff <= STATUS_LOADED;
      end else if (cmd.set_range) begin
         res_value_ff  <= '0;
         res_status_ff <= STATUS_RANGE;
      end else if (cmd.set_hit) begin
         res_value_ff  <= hit_val_ff;
         res_status_ff <= STATUS_EXACT;
      end else if (cmd.set_interp) begin
         res_value_ff  <= fa_ff + signed'(q16);
         res_status_ff <= STATUS_INTERP;
      end

      if (cmd.out_load) begin
         out_value_ff  <= res_value_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign sts.too_few  = (n_sat < CNT_W'(2));
   assign sts.hit      = hit_ff;
   assign sts.found    = found_ff;
   assign sts.scan_end = (rd_addr_ff == n_ff) && !rd_vld_ff;
   assign sts.div_done = (div_cnt_ff == '0);

   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;

`ifndef SYNTH
   a_interp_after_div : assert property (@(posedge clock) disable iff (reset)
      cmd.set_interp |-> (div_cnt_ff == '0) && (rem_ff < den_ff))
      else $error("interpolation taken before divider settled");
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (den_ff != '0))
      else $error("divider running on zero segment width");
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr_ff < n_ff))
      else $error("table read past entries in use");
`endif

endmodule

FILE: hdl/tli_ctrl.sv
`timescale 1ns / 1ps

module tli_ctrl
   import tli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_type,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  tli_sts_type  sts,
   output tli_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_DIV_INIT,
      S_DIV,
      S_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_take;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_FIN;
               if (req_type == REQ_LOAD) begin
                  cmd.load = 1'b1;
               end else if (sts.too_few) begin
                  cmd.set_range = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.set_hit = 1'b1;
               state_in    = S_FIN;
            end else if (sts.scan_end) begin
               if (sts.found) begin
                  state_in = S_MUL;
               end else begin
                  cmd.set_range = 1'b1;
                  state_in      = S_FIN;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.set_interp = 1'b1;
               state_in       = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("second beat taken while busy");
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("output register overwritten while held");
   a_hit_finishes : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && sts.hit |=> (state_ff == S_FIN))
      else $error("exact hit did not end scan");
`endif

endmodule

FILE: hdl/table_linear_interpolation_top.sv
`timescale 1ns / 1ps

// Piecewise linear lookup table, signed Q8.8.
// Request channel (req_valid / req_stall): a beat is either a load
// (req_type 0: req_entry_key / req_entry_value into slot req_entry_index)
// or a query (req_type 1: interpolate at req_query_key).
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// rsp_status 0 exact hit, 1 interpolated, 2 out of range, 3 load done.
// csr_write_enable / csr_write_data set the number of entries in use;
// write only while no request is in flight.
// One request is worked at a time. A load's response passes through the
// result register and the output register. A query walks the table one
// entry per cycle through the single read port; an exact hit ends the walk
// with that entry's value, no bracketing segment gives out of range, else
// a multiply, a divider setup and the bit-serial divider follow. A query
// with fewer than two entries in use answers out of range without a scan.
// The next request is taken the cycle after a result moves out.
// The response sits in an output register: the next request is taken
// while it waits, and a finished result waits in place while rsp_stall
// is high. Reset clears the controller, the response valid and the entry
// count; table contents are undefined until loaded.

module table_linear_interpolation_top
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_enable,
   input  logic [CSR_W-1:0]          csr_write_data,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [DATA_W-1:0]  req_entry_key,
   input  logic signed [DATA_W-1:0]  req_entry_value,
   input  logic signed [DATA_W-1:0]  req_query_key,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_result_value,
   output logic [STAT_W-1:0]         rsp_status
);

   tli_cmd_type cmd;
   tli_sts_type sts;

   // sequencer: scan, multiply, divide, hand off to output register
   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table memory, segment search, multiplier, divider, result registers
   tli_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_entry_index  (req_entry_index),
      .req_entry_key    (req_entry_key),
      .req_entry_value  (req_entry_value),
      .req_query_key    (req_query_key),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule
